FILE: rtl/cartridge_bank_mapper_irq_defines.svh
// Assertion macros for the cartridge bank mapper checker.
// Used by cbm_checker.sv only; no other dependencies.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_DEFINES_SVH

// same-cycle implication, quiet during reset
`define CBM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbm assertion failed");

// next-cycle implication, quiet during reset
`define CBM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbm assertion failed");

// next-cycle implication, also checked across reset
`define CBM_ASSERT_NXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cbm assertion failed");

`endif

FILE: rtl/cbm_pkg.sv
// Shared types, constants and codes for the cartridge bank mapper.
// No dependencies.
`default_nettype none

package cbm_pkg;

  localparam int unsigned PRG_SLOTS           = 4;
  localparam int unsigned CHR_SLOTS           = 8;
  localparam int unsigned CYCLES_PER_LINE_DEF = 113;

  localparam logic [9:0] PRG_BANK_COUNT_RESET = 10'd32;

  // request function codes
  localparam logic [2:0] FUNC_HIGH_WRITE = 3'd0;
  localparam logic [2:0] FUNC_LOW_WRITE  = 3'd1;
  localparam logic [2:0] FUNC_LOW_READ   = 3'd2;
  localparam logic [2:0] FUNC_PRG_XLATE  = 3'd3;
  localparam logic [2:0] FUNC_CHR_XLATE  = 3'd4;
  localparam logic [2:0] FUNC_SCANLINE   = 3'd5;
  localparam logic [2:0] FUNC_CART_RESET = 3'd6;

  // mirroring modes
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIRROR_PAGE0      = 2'd2;
  localparam logic [1:0] MIRROR_PAGE1      = 2'd3;

  // high-area register addresses
  localparam logic [15:0] ADDR_BANK_SEL_A  = 16'h8000;
  localparam logic [15:0] ADDR_BANK_SEL_B  = 16'hB000;
  localparam logic [15:0] ADDR_BANK_SEL_C  = 16'hB0FF;
  localparam logic [15:0] ADDR_BANK_SEL_D  = 16'hB1FF;
  localparam logic [15:0] ADDR_MIRROR      = 16'h8100;
  localparam logic [15:0] ADDR_IRQ_LO      = 16'h8200;
  localparam logic [15:0] ADDR_IRQ_HI      = 16'h8201;
  localparam logic [15:0] ADDR_PRG_FIRST   = 16'h8300;
  localparam logic [15:0] ADDR_PRG_LAST    = 16'h8302;
  localparam logic [15:0] ADDR_CHR_FIRST   = 16'h8310;
  localparam logic [15:0] ADDR_CHR_LAST    = 16'h8317;
  localparam logic [15:0] ADDR_PRG_PAIR    = 16'h8318;

  // low-area scratch register
  localparam logic [15:0] ADDR_SCRATCH_FIRST = 16'h5101;
  localparam logic [15:0] ADDR_SCRATCH_LAST  = 16'h5103;
  localparam logic [15:0] SCRATCH_MATCH      = 16'h5100;

  localparam logic [7:0] BANK_SEL_OUTER = 8'h30;
  localparam logic [7:0] BANK_SEL_INNER = 8'h3F;
  localparam logic [7:0] BANK_SEL_LOW   = 8'h0F;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [PRG_SLOTS-1:0][8:0] prg_slot;
    logic [CHR_SLOTS-1:0][9:0] chr_slot;
    logic [1:0]                mirror_mode;
    logic [7:0]                scratch_byte;
    logic                      irq_hit;
  } view_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [21:0] prg_rom_address;
    logic [19:0] chr_rom_address;
    logic        nametable_page;
    logic        irq;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/cbm_req_if.sv
// Request channel of the cartridge bank mapper: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface cbm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, func, address, data, input ready);
  modport sink   (input valid, func, address, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/cbm_res_if.sv
// Result channel of the cartridge bank mapper: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface cbm_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [21:0] prg_rom_address;
  logic [19:0] chr_rom_address;
  logic        nametable_page;
  logic        irq;

  modport source (output valid, read_data, prg_rom_address, chr_rom_address,
                  nametable_page, irq, input ready);
  modport sink   (input valid, read_data, prg_rom_address, chr_rom_address,
                  nametable_page, irq, output ready);
endinterface

`default_nettype wire

FILE: rtl/cartridge_bank_mapper_irq.sv
// Top level of the cartridge bank mapper with scanline IRQ counter.
// Depends on cbm_pkg, cbm_req_if, cbm_res_if, cbm_state and cbm_result.
//
// One request per clock is taken while the result side does not stall, and every
// request gives exactly one result. A request is held in an input register; once
// the output register is free or being taken, its result is formed from the current
// mapper state and captured in the output register while the state updates.
// The output register and the input register decouple the sides, so a stalled
// result still lets one more request in. There is no clearing pass: all state
// resets at once. The user must write the bank count register only while no
// request is in flight; the block itself does not enforce this.
`default_nettype none

module cartridge_bank_mapper_irq #(
  parameter int unsigned CYCLES_PER_LINE = cbm_pkg::CYCLES_PER_LINE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [9:0] cfg_wr_data,
  cbm_req_if.sink         req,
  cbm_res_if.source       res
);

  logic           stage_valid;
  cbm_pkg::item_t stage_item;
  logic           out_valid;
  cbm_pkg::res_t  out_res;
  cbm_pkg::res_t  res_next;
  cbm_pkg::view_t view;
  logic           advance;

  assign advance   = stage_valid && (!out_valid || res.ready);
  assign req.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      stage_item.func    <= req.func;
      stage_item.address <= req.address;
      stage_item.data    <= req.data;
    end
  end

  cbm_state #(
    .CYCLES_PER_LINE(CYCLES_PER_LINE)
  ) u_state (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .step       (advance),
    .item       (stage_item),
    .view       (view)
  );

  cbm_result u_result (
    .item(stage_item),
    .view(view),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign res.valid           = out_valid;
  assign res.read_data       = out_res.read_data;
  assign res.prg_rom_address = out_res.prg_rom_address;
  assign res.chr_rom_address = out_res.chr_rom_address;
  assign res.nametable_page  = out_res.nametable_page;
  assign res.irq             = out_res.irq;

endmodule

`default_nettype wire

FILE: rtl/cbm_state.sv
// Mapper state: bank slots, mirroring, scratch byte, IRQ counter, bank count.
// Depends on cbm_pkg.
`default_nettype none

module cbm_state #(
  parameter int unsigned CYCLES_PER_LINE = cbm_pkg::CYCLES_PER_LINE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [9:0]    cfg_wr_data,
  input  wire logic          step,
  input  wire cbm_pkg::item_t item,
  output cbm_pkg::view_t     view
);

  localparam logic [15:0] LINE = 16'(CYCLES_PER_LINE);

  logic [9:0]                          prg_bank_count;
  logic [7:0]                          bank_select, bank_select_next;
  logic [7:0]                          scratch_byte, scratch_byte_next;
  logic [cbm_pkg::PRG_SLOTS-1:0][8:0]  prg_slot, prg_slot_next;
  logic [cbm_pkg::CHR_SLOTS-1:0][9:0]  chr_slot, chr_slot_next;
  logic [1:0]                          mirror_mode, mirror_mode_next;
  logic [15:0]                         irq_count, irq_count_next;
  logic                                irq_armed, irq_armed_next;

  logic [8:0] reset_slot2, reset_slot3;
  logic [7:0] pair_base;
  logic       irq_hit;

  assign irq_hit = irq_armed && (irq_count <= LINE);

  always_comb begin
    if (prg_bank_count >= cbm_pkg::PRG_BANK_COUNT_RESET) begin
      reset_slot2 = 9'd30;
      reset_slot3 = 9'd31;
    end else begin
      reset_slot2 = 9'(prg_bank_count - 10'd2);
      reset_slot3 = 9'(prg_bank_count - 10'd1);
    end
  end

  assign pair_base = (bank_select & cbm_pkg::BANK_SEL_OUTER) | item.data;

  always_comb begin
    bank_select_next  = bank_select;
    scratch_byte_next = scratch_byte;
    prg_slot_next     = prg_slot;
    chr_slot_next     = chr_slot;
    mirror_mode_next  = mirror_mode;
    irq_count_next    = irq_count;
    irq_armed_next    = irq_armed;
    if (step) begin
      unique case (item.func)
        cbm_pkg::FUNC_HIGH_WRITE: begin
          if (item.address == cbm_pkg::ADDR_BANK_SEL_A || item.address == cbm_pkg::ADDR_BANK_SEL_B ||
              item.address == cbm_pkg::ADDR_BANK_SEL_C || item.address == cbm_pkg::ADDR_BANK_SEL_D) begin
            bank_select_next = item.data;
            prg_slot_next[0] = {2'b00, item.data[5:0], 1'b0};
            prg_slot_next[1] = {2'b00, item.data[5:0], 1'b1};
            prg_slot_next[2] = {2'b00, item.data[5:4], cbm_pkg::BANK_SEL_LOW[3:0], 1'b0};
            prg_slot_next[3] = {2'b00, item.data[5:4], cbm_pkg::BANK_SEL_LOW[3:0], 1'b1};
          end else if (item.address == cbm_pkg::ADDR_MIRROR) begin
            mirror_mode_next = item.data[1:0];
          end else if (item.address == cbm_pkg::ADDR_IRQ_LO) begin
            irq_count_next[7:0] = item.data;
          end else if (item.address == cbm_pkg::ADDR_IRQ_HI) begin
            irq_count_next[15:8] = item.data;
            irq_armed_next       = (item.data != 8'd0);
          end else if (item.address >= cbm_pkg::ADDR_PRG_FIRST &&
                       item.address <= cbm_pkg::ADDR_PRG_LAST) begin
            prg_slot_next[2'(item.address - cbm_pkg::ADDR_PRG_FIRST)] = {1'b0, item.data};
          end else if (item.address >= cbm_pkg::ADDR_CHR_FIRST &&
                       item.address <= cbm_pkg::ADDR_CHR_LAST) begin
            chr_slot_next[3'(item.address - cbm_pkg::ADDR_CHR_FIRST)] =
              {bank_select[5:4], item.data};
          end else if (item.address == cbm_pkg::ADDR_PRG_PAIR) begin
            prg_slot_next[0] = {pair_base, 1'b0};
            prg_slot_next[1] = {pair_base, 1'b1};
          end
        end
        cbm_pkg::FUNC_LOW_WRITE: begin
          if (item.address >= cbm_pkg::ADDR_SCRATCH_FIRST &&
              item.address <= cbm_pkg::ADDR_SCRATCH_LAST) begin
            scratch_byte_next = item.data;
          end
        end
        cbm_pkg::FUNC_SCANLINE: begin
          if (irq_hit) begin
            irq_armed_next = 1'b0;
          end else if (irq_armed) begin
            irq_count_next = irq_count - LINE;
          end
        end
        cbm_pkg::FUNC_CART_RESET: begin
          bank_select_next  = 8'd0;
          scratch_byte_next = 8'd0;
          prg_slot_next[0]  = 9'd0;
          prg_slot_next[1]  = 9'd1;
          prg_slot_next[2]  = reset_slot2;
          prg_slot_next[3]  = reset_slot3;
          for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++) begin
            chr_slot_next[i] = 10'(i);
          end
          irq_count_next = 16'd0;
          irq_armed_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= cbm_pkg::PRG_BANK_COUNT_RESET;
      bank_select    <= 8'd0;
      scratch_byte   <= 8'd0;
      prg_slot[0]    <= 9'd0;
      prg_slot[1]    <= 9'd1;
      prg_slot[2]    <= 9'd30;
      prg_slot[3]    <= 9'd31;
      for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++) begin
        chr_slot[i] <= 10'(i);
      end
      mirror_mode    <= cbm_pkg::MIRROR_VERTICAL;
      irq_count      <= 16'd0;
      irq_armed      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        prg_bank_count <= cfg_wr_data;
      end
      bank_select  <= bank_select_next;
      scratch_byte <= scratch_byte_next;
      prg_slot     <= prg_slot_next;
      chr_slot     <= chr_slot_next;
      mirror_mode  <= mirror_mode_next;
      irq_count    <= irq_count_next;
      irq_armed    <= irq_armed_next;
    end
  end

  assign view.prg_slot     = prg_slot;
  assign view.chr_slot     = chr_slot;
  assign view.mirror_mode  = mirror_mode;
  assign view.scratch_byte = scratch_byte;
  assign view.irq_hit      = irq_hit;

endmodule

`default_nettype wire

FILE: rtl/cbm_result.sv
// Result logic: low reads, program/character translation, nametable page, IRQ.
// Depends on cbm_pkg.
`default_nettype none

module cbm_result (
  input  wire cbm_pkg::item_t item,
  input  wire cbm_pkg::view_t view,
  output cbm_pkg::res_t       res
);

  logic [13:0] ppu_addr;
  logic        page;

  assign ppu_addr = item.address[13:0];

  always_comb begin
    case (view.mirror_mode)
      cbm_pkg::MIRROR_VERTICAL:   page = ppu_addr[10];
      cbm_pkg::MIRROR_HORIZONTAL: page = ppu_addr[11];
      cbm_pkg::MIRROR_PAGE0:      page = 1'b0;
      cbm_pkg::MIRROR_PAGE1:      page = 1'b1;
      default:                    page = 1'b0;
    endcase
  end

  always_comb begin
    res = '0;
    unique case (item.func)
      cbm_pkg::FUNC_LOW_READ: begin
        if ((item.address & cbm_pkg::SCRATCH_MATCH) == cbm_pkg::SCRATCH_MATCH) begin
          res.read_data = view.scratch_byte;
        end else begin
          res.read_data = item.address[15:8];
        end
      end
      cbm_pkg::FUNC_PRG_XLATE: begin
        if (item.address[15]) begin
          res.prg_rom_address = {view.prg_slot[item.address[14:13]], item.address[12:0]};
        end
      end
      cbm_pkg::FUNC_CHR_XLATE: begin
        if (!ppu_addr[13]) begin
          res.chr_rom_address = {view.chr_slot[ppu_addr[12:10]], ppu_addr[9:0]};
        end else if (ppu_addr[13:8] != 6'h3F) begin
          res.nametable_page = page;
        end
      end
      cbm_pkg::FUNC_SCANLINE: begin
        res.irq = view.irq_hit;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/cbm_checker.sv
// Port-level checks for cartridge_bank_mapper_irq, attached by bind.
// Depends on cartridge_bank_mapper_irq_defines.svh.
`default_nettype none
`include "cartridge_bank_mapper_irq_defines.svh"

module cbm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [7:0]  read_data,
  input wire logic [21:0] prg_rom_address,
  input wire logic [19:0] chr_rom_address,
  input wire logic        nametable_page,
  input wire logic        irq
);

  // stalled result stays valid and holds all fields but the nametable page
  `CBM_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(read_data) && $stable(prg_rom_address) && $stable(chr_rom_address) && $stable(irq))

  // an interrupt result carries nothing else
  `CBM_ASSERT_IMP(a_irq_alone, clk, rst, res_valid && irq, read_data == 8'd0 && prg_rom_address == 22'd0 && chr_rom_address == 20'd0 && !nametable_page)

  // nametable page excludes a character address
  `CBM_ASSERT_IMP(a_page_alone, clk, rst, res_valid && nametable_page, chr_rom_address == 20'd0 && prg_rom_address == 22'd0 && read_data == 8'd0)

  // nothing valid straight after reset
  `CBM_ASSERT_NXT_ALL(a_reset_empty, clk, rst, !res_valid)

endmodule

bind cartridge_bank_mapper_irq cbm_checker u_cbm_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .read_data      (res.read_data),
  .prg_rom_address(res.prg_rom_address),
  .chr_rom_address(res.chr_rom_address),
  .nametable_page (res.nametable_page),
  .irq            (res.irq)
);

`default_nettype wire

FILE: dv/testbench.sv
// Testbench for cartridge_bank_mapper_irq: random and directed bus requests with an in-line
// mapper model, checked field by field against every result.
// Depends on cbm_pkg, cbm_req_if, cbm_res_if and the mapper RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_LEN     = 165;
  localparam int SETTLE_CYCLES = 4;

  // func value with no meaning
  localparam logic [2:0] FUNC_UNUSED = 3'd7;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [9:0] cfg_wr_data;

  cbm_req_if req_ch ();
  cbm_res_if res_ch ();

  cartridge_bank_mapper_irq dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .res         (res_ch)
  );

  // mapper model state
  logic [9:0]  m_bank_count;
  logic [7:0]  m_bank_sel;
  logic [7:0]  m_scratch;
  logic [8:0]  m_prg [4];
  logic [9:0]  m_chr [8];
  logic [1:0]  m_mirror;
  logic [15:0] m_irq_count;
  logic        m_irq_armed;

  cbm_pkg::item_t bus_requests [$];
  cbm_pkg::res_t  owed_results [$];
  cbm_pkg::item_t next_req;
  cbm_pkg::res_t  want;

  int send_gap;
  int stall_left;
  int stall_draw;
  int hold_left;
  int hold_requests;
  int hold_served;
  int quiet_cycles;
  int fail_count;
  bit idle_mode;

  always #1 clk = ~clk;

  function automatic void cart_reset_state();
    m_bank_sel = '0;
    m_scratch  = '0;
    m_prg[0]   = 9'd0;
    m_prg[1]   = 9'd1;
    if (m_bank_count >= 10'd32) begin
      m_prg[2] = 9'd30;
      m_prg[3] = 9'd31;
    end else begin
      m_prg[2] = 9'(m_bank_count - 10'd2);
      m_prg[3] = 9'(m_bank_count - 10'd1);
    end
    for (int i = 0; i < 8; i++) m_chr[i] = 10'(i);
    m_irq_armed = 1'b0;
    m_irq_count = '0;
  endfunction

  function automatic void prg_pair(int first, logic [7:0] base);
    m_prg[first]     = {base, 1'b0};
    m_prg[first + 1] = {base, 1'b1};
  endfunction

  function automatic void high_area_write(logic [15:0] a, logic [7:0] d);
    case (a)
      cbm_pkg::ADDR_BANK_SEL_A, cbm_pkg::ADDR_BANK_SEL_B,
      cbm_pkg::ADDR_BANK_SEL_C, cbm_pkg::ADDR_BANK_SEL_D: begin
        m_bank_sel = d;
        prg_pair(0, d & cbm_pkg::BANK_SEL_INNER);
        prg_pair(2, (d & cbm_pkg::BANK_SEL_OUTER) | cbm_pkg::BANK_SEL_LOW);
      end
      cbm_pkg::ADDR_MIRROR: m_mirror = d[1:0];
      cbm_pkg::ADDR_IRQ_LO: m_irq_count[7:0] = d;
      cbm_pkg::ADDR_IRQ_HI: begin
        m_irq_count[15:8] = d;
        m_irq_armed = (d != 8'd0);
      end
      cbm_pkg::ADDR_PRG_PAIR: prg_pair(0, (m_bank_sel & cbm_pkg::BANK_SEL_OUTER) | d);
      default: begin
        if (a >= cbm_pkg::ADDR_PRG_FIRST && a <= cbm_pkg::ADDR_PRG_LAST)
          m_prg[a[1:0]] = {1'b0, d};
        else if (a >= cbm_pkg::ADDR_CHR_FIRST && a <= cbm_pkg::ADDR_CHR_LAST)
          m_chr[a[2:0]] = {m_bank_sel[5:4], d};
      end
    endcase
  endfunction

  function automatic cbm_pkg::res_t mapper_step(cbm_pkg::item_t r);
    cbm_pkg::res_t o;
    logic [13:0]   ppu;
    o   = '0;
    ppu = r.address[13:0];
    case (r.func)
      cbm_pkg::FUNC_HIGH_WRITE: high_area_write(r.address, r.data);
      cbm_pkg::FUNC_LOW_WRITE: begin
        if (r.address >= cbm_pkg::ADDR_SCRATCH_FIRST &&
            r.address <= cbm_pkg::ADDR_SCRATCH_LAST) m_scratch = r.data;
      end
      cbm_pkg::FUNC_LOW_READ: begin
        o.read_data = ((r.address & cbm_pkg::SCRATCH_MATCH) == cbm_pkg::SCRATCH_MATCH) ?
                      m_scratch : r.address[15:8];
      end
      cbm_pkg::FUNC_PRG_XLATE: begin
        if (r.address[15]) o.prg_rom_address = {m_prg[r.address[14:13]], r.address[12:0]};
      end
      cbm_pkg::FUNC_CHR_XLATE: begin
        if (!ppu[13]) begin
          o.chr_rom_address = {m_chr[ppu[12:10]], ppu[9:0]};
        end else if (ppu[13:8] != 6'h3F) begin
          case (m_mirror)
            cbm_pkg::MIRROR_VERTICAL:   o.nametable_page = ppu[10];
            cbm_pkg::MIRROR_HORIZONTAL: o.nametable_page = ppu[11];
            cbm_pkg::MIRROR_PAGE0:      o.nametable_page = 1'b0;
            default:                    o.nametable_page = 1'b1;
          endcase
        end
      end
      cbm_pkg::FUNC_SCANLINE: begin
        if (m_irq_armed) begin
          if (m_irq_count <= 16'(cbm_pkg::CYCLES_PER_LINE_DEF)) begin
            o.irq = 1'b1;
            m_irq_armed = 1'b0;
          end else begin
            m_irq_count = m_irq_count - 16'(cbm_pkg::CYCLES_PER_LINE_DEF);
          end
        end
      end
      cbm_pkg::FUNC_CART_RESET: cart_reset_state();
      default: ;
    endcase
    return o;
  endfunction

  function automatic cbm_pkg::item_t bus_req(logic [2:0] f, logic [15:0] a, logic [7:0] d);
    cbm_pkg::item_t r;
    r.func    = f;
    r.address = a;
    r.data    = d;
    return r;
  endfunction

  // mostly register hits, translations and ticks; the rest is noise
  function automatic cbm_pkg::item_t random_req();
    int unsigned pick;
    logic [15:0] a;
    logic [7:0]  d;
    pick = $urandom_range(0, 99);
    a    = 16'($urandom);
    d    = 8'($urandom);
    if (pick < 25) begin
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 8))
          0: a = cbm_pkg::ADDR_BANK_SEL_A;
          1: a = ($urandom_range(0, 1) != 0) ? cbm_pkg::ADDR_BANK_SEL_B :
                                               cbm_pkg::ADDR_BANK_SEL_C;
          2: a = cbm_pkg::ADDR_BANK_SEL_D;
          3: a = cbm_pkg::ADDR_MIRROR;
          4: a = cbm_pkg::ADDR_IRQ_LO;
          5: begin
            a = cbm_pkg::ADDR_IRQ_HI;
            if ($urandom_range(0, 3) != 0) d = 8'($urandom_range(0, 2));
          end
          6: a = cbm_pkg::ADDR_PRG_FIRST + 16'($urandom_range(0, 2));
          7: a = cbm_pkg::ADDR_CHR_FIRST + 16'($urandom_range(0, 7));
          default: a = cbm_pkg::ADDR_PRG_PAIR;
        endcase
      end
      return bus_req(cbm_pkg::FUNC_HIGH_WRITE, a, d);
    end
    if (pick < 45) begin
      if ($urandom_range(0, 4) != 0) a[15] = 1'b1;
      return bus_req(cbm_pkg::FUNC_PRG_XLATE, a, d);
    end
    if (pick < 65) return bus_req(cbm_pkg::FUNC_CHR_XLATE, a, d);
    if (pick < 80) return bus_req(cbm_pkg::FUNC_SCANLINE, a, d);
    if (pick < 88) begin
      if ($urandom_range(0, 9) < 7) a = cbm_pkg::SCRATCH_MATCH + 16'($urandom_range(0, 4));
      return bus_req(cbm_pkg::FUNC_LOW_WRITE, a, d);
    end
    if (pick < 96) begin
      if ($urandom_range(0, 1) != 0) a[15:8] = cbm_pkg::SCRATCH_MATCH[15:8];
      return bus_req(cbm_pkg::FUNC_LOW_READ, a, d);
    end
    if (pick < 98) return bus_req(cbm_pkg::FUNC_CART_RESET, a, d);
    return bus_req(FUNC_UNUSED, a, d);
  endfunction

  task automatic wait_quiet();
    do @(negedge clk);
    while (bus_requests.size() != 0 || req_ch.valid || owed_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bank_count(logic [9:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    m_bank_count = v;
    @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        owed_results.push_back(mapper_step(bus_req(req_ch.func, req_ch.address, req_ch.data)));
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (bus_requests.size() != 0) begin
          next_req       = bus_requests.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.func    <= next_req.func;
          req_ch.address <= next_req.address;
          req_ch.data    <= next_req.data;
          send_gap       <= idle_mode ? int'($urandom_range(0, 11)) : 0;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (owed_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (res_ch.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, res_ch.read_data);
            fail_count++;
          end
          if (res_ch.prg_rom_address !== want.prg_rom_address) begin
            $error("prg_rom_address: expected %0h, got %0h",
                   want.prg_rom_address, res_ch.prg_rom_address);
            fail_count++;
          end
          if (res_ch.chr_rom_address !== want.chr_rom_address) begin
            $error("chr_rom_address: expected %0h, got %0h",
                   want.chr_rom_address, res_ch.chr_rom_address);
            fail_count++;
          end
          if (res_ch.nametable_page !== want.nametable_page) begin
            $error("nametable_page: expected %0h, got %0h",
                   want.nametable_page, res_ch.nametable_page);
            fail_count++;
          end
          if (res_ch.irq !== want.irq) begin
            $error("irq: expected %0h, got %0h", want.irq, res_ch.irq);
            fail_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served  <= hold_requests;
        hold_left    <= HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else if (res_ch.valid && res_ch.ready && idle_mode) begin
        stall_draw    = int'($urandom_range(0, 11));
        stall_left   <= (stall_draw > 0) ? stall_draw - 1 : 0;
        res_ch.ready <= (stall_draw == 0);
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [9:0] bank_counts [8];
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    req_ch.valid   = 1'b0;
    req_ch.func    = cbm_pkg::FUNC_HIGH_WRITE;
    req_ch.address = '0;
    req_ch.data    = '0;
    res_ch.ready   = 1'b0;
    hold_requests  = 0;
    hold_served    = 0;
    fail_count     = 0;
    quiet_cycles   = 0;
    idle_mode      = 1'b1;
    m_bank_count   = cbm_pkg::PRG_BANK_COUNT_RESET;
    m_mirror       = cbm_pkg::MIRROR_VERTICAL;
    cart_reset_state();
    bank_counts = '{10'd0, 10'd1, 10'd2, 10'd31, 10'd32, 10'd512, 10'd1023,
                    10'($urandom_range(0, 1023))};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, every function, boundary regions
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_PRG_XLATE, 16'hFFFF, 8'h00));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_PRG_XLATE, 16'h7FFF, 8'hFF));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_HIGH_WRITE, cbm_pkg::ADDR_BANK_SEL_A, 8'hFF));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_HIGH_WRITE, cbm_pkg::ADDR_PRG_PAIR, 8'hFF));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_PRG_XLATE, 16'h8000, 8'h00));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_HIGH_WRITE, cbm_pkg::ADDR_CHR_LAST, 8'hFF));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_CHR_XLATE, 16'h1FFF, 8'h00));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_HIGH_WRITE, cbm_pkg::ADDR_MIRROR, 8'hFF));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_CHR_XLATE, 16'h2000, 8'h00));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_CHR_XLATE, 16'h3EFF, 8'h00));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_CHR_XLATE, 16'hFFFF, 8'h00));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_LOW_WRITE, cbm_pkg::ADDR_SCRATCH_FIRST, 8'hFF));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_LOW_WRITE, cbm_pkg::SCRATCH_MATCH, 8'h55));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_LOW_READ, 16'hFFFF, 8'h00));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_LOW_READ, 16'h0000, 8'h00));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_HIGH_WRITE, cbm_pkg::ADDR_IRQ_LO, 8'h71));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_HIGH_WRITE, cbm_pkg::ADDR_IRQ_HI, 8'h01));
    repeat (5) bus_requests.push_back(bus_req(cbm_pkg::FUNC_SCANLINE, 16'h0000, 8'h00));
    bus_requests.push_back(bus_req(FUNC_UNUSED, 16'hFFFF, 8'hFF));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_CART_RESET, 16'h0000, 8'h00));
    bus_requests.push_back(bus_req(cbm_pkg::FUNC_PRG_XLATE, 16'hE000, 8'h00));
    wait_quiet();

    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = (ph % 3 != 1);
      write_bank_count(bank_counts[ph]);
      bus_requests.push_back(bus_req(cbm_pkg::FUNC_CART_RESET, 16'($urandom), 8'($urandom)));
      for (int i = 0; i < PHASE_LEN; i++) begin
        bus_requests.push_back(random_req());
        // sink held off while requests keep coming
        if (i == PHASE_LEN / 2 && (ph == 2 || ph == 5)) hold_requests++;
      end
      wait_quiet();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
